FILE: rtl/xps_pkg.sv
// Shared types and constants for the XNOR/popcount binary scorer.
// No dependencies; every other file in rtl/ imports this package.
package xps_pkg;

    // Depth of the job queue between the word front end and the scoring back end.
    localparam int QUEUE_DEPTH = 4;

    // Configuration register indexes.
    localparam int CFG_IDX_W = 8;
    localparam logic [CFG_IDX_W-1:0] REG_LATENT_WORDS = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_USR_SCALE    = 8'd1;
    localparam logic [CFG_IDX_W-1:0] REG_USR_OFFSET   = 8'd2;
    localparam logic [CFG_IDX_W-1:0] REG_ITEM_COUNT   = 8'd3;

    // Largest batch the 16-bit item index can number.
    localparam logic [16:0] MAX_ITEMS = 17'd65536;

    localparam logic signed [63:0] SCORE_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
    localparam logic signed [63:0] SCORE_MIN = 64'sh8000_0000_0000_0000;

    // Per-item data handed from the front end to the back end.
    typedef struct packed {
        logic [31:0]        item_norm;
        logic signed [31:0] item_bias;
        logic [15:0]        item_index;
        logic               last_item;
    } job_t;

    localparam int JOB_W = $bits(job_t);

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_PROD,
        BK_LO,
        BK_HI,
        BK_MSUM,
        BK_BIAS,
        BK_SAT
    } bk_state_t;

endpackage

FILE: rtl/xps_queue.sv
// Small register FIFO that decouples the word front end from the scoring back end.
// Depends on xps_pkg for the queue depth.
module xps_queue import xps_pkg::*; #(
    parameter int WIDTH = 8
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    output logic             full,
    input  logic             pop,
    output logic             valid,
    output logic [WIDTH-1:0] pop_data
);

    localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    logic [WIDTH-1:0] slot_reg [QUEUE_DEPTH];
    logic [PW-1:0]    wr_ptr_reg;
    logic [PW-1:0]    rd_ptr_reg;
    logic [CW-1:0]    count_reg;
    logic [PW-1:0]    wr_ptr_next;
    logic [PW-1:0]    rd_ptr_next;
    logic [CW-1:0]    count_next;

    assign full     = (count_reg == CW'(QUEUE_DEPTH));
    assign valid    = (count_reg != '0);
    assign pop_data = slot_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        !(push && full))
        else $error("queue pushed while full");

    a_no_underflow: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> valid)
        else $error("queue popped while empty");

    a_count_up: assert property (@(posedge aclk) disable iff (!aresetn)
        (push && !pop) |=> (count_reg == $past(count_reg) + 1'b1))
        else $error("queue count did not follow a push");

    a_ptr_gap: assert property (@(posedge aclk) disable iff (!aresetn)
        (count_reg == '0) |-> (wr_ptr_reg == rd_ptr_reg))
        else $error("queue pointers differ while empty");

endmodule

FILE: rtl/xps_front.sv
// Front end: accepts words, keeps the user vector store, counts XNOR agreements
// and hands one job per finished item to the queue. Depends on xps_pkg.
module xps_front import xps_pkg::*; #(
    parameter int MAX_WORDS = 64,
    parameter int PTR_W     = 6,
    parameter int CNT_W     = 7,
    parameter int SUM_W     = 12
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic               s_mode,
    input  logic [31:0]        s_vector_word,
    input  logic [31:0]        s_item_norm,
    input  logic signed [31:0] s_item_bias,
    input  logic [CNT_W-1:0]   words_eff,
    input  logic [16:0]        items_eff,
    input  logic               q_full,
    output logic               q_push,
    output job_t               q_job,
    output logic [SUM_W-1:0]   q_sum,
    output logic [CNT_W-1:0]   q_words
);

    localparam int CMP_W = CNT_W + 1;

    function automatic logic [5:0] ones32(input logic [31:0] v);
        logic [1:0] l1 [16];
        logic [2:0] l2 [8];
        logic [3:0] l3 [4];
        logic [4:0] l4 [2];
        for (int i = 0; i < 16; i++) l1[i] = {1'b0, v[2*i]} + {1'b0, v[2*i+1]};
        for (int i = 0; i < 8; i++)  l2[i] = {1'b0, l1[2*i]} + {1'b0, l1[2*i+1]};
        for (int i = 0; i < 4; i++)  l3[i] = {1'b0, l2[2*i]} + {1'b0, l2[2*i+1]};
        for (int i = 0; i < 2; i++)  l4[i] = {1'b0, l3[2*i]} + {1'b0, l3[2*i+1]};
        return {1'b0, l4[0]} + {1'b0, l4[1]};
    endfunction

    logic [31:0]      user_store [MAX_WORDS];
    logic [31:0]      ram_q_reg;

    logic [PTR_W-1:0] load_ptr_reg;
    logic [PTR_W-1:0] word_ptr_reg;
    logic [15:0]      item_counter_reg;
    logic [SUM_W-1:0] sum_reg;

    logic             s1_valid_reg;
    logic             s1_last_reg;
    logic [31:0]      s1_word_reg;
    job_t             s1_job_reg;
    logic [CNT_W-1:0] s1_words_reg;

    logic             s_accept;
    logic             blocked;
    logic [CMP_W-1:0] ld_inc;
    logic [CMP_W-1:0] wd_inc;
    logic             ld_wrap;
    logic             wd_last;
    logic [16:0]      ic_inc;
    logic             batch_last;
    logic [5:0]       agree;
    logic [SUM_W-1:0] sum_add;

    // A finished item waits in stage 1 until the queue has room.
    assign blocked  = s1_valid_reg && s1_last_reg && q_full;
    assign s_ready  = !blocked;
    assign s_accept = s_valid && s_ready;

    assign ld_inc     = CMP_W'(load_ptr_reg) + 1'b1;
    assign wd_inc     = CMP_W'(word_ptr_reg) + 1'b1;
    assign ld_wrap    = (ld_inc >= CMP_W'(words_eff));
    assign wd_last    = (wd_inc >= CMP_W'(words_eff));
    assign ic_inc     = {1'b0, item_counter_reg} + 17'd1;
    assign batch_last = (ic_inc >= items_eff);

    assign agree   = ones32(~(ram_q_reg ^ s1_word_reg));
    assign sum_add = sum_reg + SUM_W'(agree);

    assign q_push  = s1_valid_reg && s1_last_reg && !q_full;
    assign q_job   = s1_job_reg;
    assign q_sum   = sum_add;
    assign q_words = s1_words_reg;

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            if (!s_mode) begin
                user_store[load_ptr_reg] <= s_vector_word;
            end else begin
                ram_q_reg <= user_store[word_ptr_reg];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            load_ptr_reg     <= '0;
            word_ptr_reg     <= '0;
            item_counter_reg <= '0;
            sum_reg          <= '0;
            s1_valid_reg     <= 1'b0;
        end else begin
            s1_valid_reg <= blocked || (s_accept && s_mode);
            if (s1_valid_reg && !blocked) begin
                sum_reg <= s1_last_reg ? '0 : sum_add;
            end
            if (s_accept && !s_mode) begin
                load_ptr_reg <= ld_wrap ? '0 : PTR_W'(ld_inc);
            end
            if (s_accept && s_mode) begin
                if (wd_last) begin
                    word_ptr_reg     <= '0;
                    item_counter_reg <= batch_last ? 16'd0 : ic_inc[15:0];
                end else begin
                    word_ptr_reg <= PTR_W'(wd_inc);
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept && s_mode) begin
            s1_last_reg           <= wd_last;
            s1_word_reg           <= s_vector_word;
            s1_words_reg          <= words_eff;
            s1_job_reg.item_norm  <= s_item_norm;
            s1_job_reg.item_bias  <= s_item_bias;
            s1_job_reg.item_index <= item_counter_reg;
            s1_job_reg.last_item  <= batch_last;
        end
    end

endmodule

FILE: rtl/xps_back.sv
// Back end: turns one queued job into a saturated Q16.16 score through its state sequence
// and holds it in the output register. Depends on xps_pkg.
module xps_back import xps_pkg::*; #(
    parameter int CNT_W = 7,
    parameter int SUM_W = 12
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               q_valid,
    output logic               q_pop,
    input  job_t               q_job,
    input  logic [SUM_W-1:0]   q_sum,
    input  logic [CNT_W-1:0]   q_words,
    input  logic [31:0]        usr_scale,
    input  logic signed [31:0] usr_offset,
    output logic               m_valid,
    input  logic               m_ready,
    output logic signed [63:0] m_score,
    output logic [15:0]        m_item_index,
    output logic               m_last_item
);

    localparam int DW   = SUM_W + 2;
    localparam int A_W  = SUM_W;
    localparam int LO_W = 32 + A_W + 1;
    localparam int HI_W = 32 + A_W;

    bk_state_t state_reg;
    bk_state_t state_next;
    logic      out_load;

    job_t               job_reg;
    logic signed [DW-1:0] diff_reg;
    logic [63:0]        p_reg;
    logic               neg_reg;
    logic [A_W-1:0]     a_reg;
    logic signed [33:0] c_reg;
    logic [LO_W-1:0]    lo_reg;
    logic [HI_W-1:0]    hi_reg;
    logic [63:0]        m_reg;
    logic [63:0]        u_reg;
    logic               fneg_reg;

    logic               m_valid_reg;
    logic signed [63:0] score_reg;
    logic [15:0]        index_reg;
    logic               last_reg;

    logic signed [DW-1:0] diff_in;
    logic signed [DW-1:0] diff_abs;
    logic signed [33:0]   bias_sum;
    logic [32:0]          cm;

    assign diff_in  = $signed({1'b0, q_sum, 1'b0}) - $signed(DW'({1'b0, q_words, 5'b0}));
    assign diff_abs = diff_reg[DW-1] ? -diff_reg : diff_reg;
    assign bias_sum = 34'(usr_offset) + 34'(job_reg.item_bias);
    assign cm       = 33'(-c_reg);

    assign m_valid      = m_valid_reg;
    assign m_score      = score_reg;
    assign m_item_index = index_reg;
    assign m_last_item  = last_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= BK_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        q_pop      = 1'b0;
        out_load   = 1'b0;
        unique case (state_reg)
            BK_IDLE: begin
                if (q_valid) begin
                    q_pop      = 1'b1;
                    state_next = BK_PROD;
                end
            end
            BK_PROD: state_next = BK_LO;
            BK_LO:   state_next = BK_HI;
            BK_HI:   state_next = BK_MSUM;
            BK_MSUM: state_next = BK_BIAS;
            BK_BIAS: state_next = BK_SAT;
            BK_SAT: begin
                if (!m_valid_reg || m_ready) begin
                    out_load   = 1'b1;
                    state_next = BK_IDLE;
                end
            end
            default: state_next = BK_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (q_pop) begin
            job_reg  <= q_job;
            diff_reg <= diff_in;
        end
        if (state_reg == BK_PROD) begin
            p_reg   <= 64'(usr_scale) * 64'(job_reg.item_norm);
            neg_reg <= diff_reg[DW-1];
            a_reg   <= diff_abs[A_W-1:0];
            // The bias sum flips with the sign of the agreement difference.
            c_reg   <= diff_reg[DW-1] ? -bias_sum : bias_sum;
        end
        if (state_reg == BK_LO) begin
            lo_reg <= LO_W'(p_reg[31:0]) * LO_W'(a_reg) + LO_W'(32'h8000);
        end
        if (state_reg == BK_HI) begin
            hi_reg <= HI_W'(p_reg[63:32]) * HI_W'(a_reg);
        end
        if (state_reg == BK_MSUM) begin
            // Magnitude in Q16.16, rounded half away from zero, wrapping at 64 bits.
            m_reg <= 64'({hi_reg, 16'b0}) + 64'(lo_reg[LO_W-1:16]);
        end
        if (state_reg == BK_BIAS) begin
            if (!c_reg[33]) begin
                u_reg    <= m_reg + 64'(c_reg[32:0]);
                fneg_reg <= neg_reg;
            end else if (m_reg >= 64'(cm)) begin
                u_reg    <= m_reg - 64'(cm);
                fneg_reg <= neg_reg;
            end else begin
                u_reg    <= 64'(cm) - m_reg;
                fneg_reg <= !neg_reg;
            end
        end
        if (out_load) begin
            if (fneg_reg) begin
                score_reg <= (u_reg > 64'h8000_0000_0000_0000) ? SCORE_MIN : $signed(-u_reg);
            end else begin
                score_reg <= u_reg[63] ? SCORE_MAX : $signed(u_reg);
            end
            index_reg <= job_reg.item_index;
            last_reg  <= job_reg.last_item;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

endmodule

FILE: rtl/xnor_popcount_binary_scorer.sv
// XNOR/popcount binary scorer, top level: configuration registers, front end, queue, back end.
// An item's last word passes front-end stage 1, the queue and the back-end states PROD, LO,
// HI, MSUM, BIAS and SAT, then the output register. The input takes one word per cycle
// unless a full queue holds back a finished item; the back end scores one job at a time.
// Reset (aresetn low, synchronous) clears pointers, counts, queue and output valid and
// restores the register defaults; the user vector store keeps its contents until written.
module xnor_popcount_binary_scorer import xps_pkg::*; #(
    parameter int MAX_WORDS = 64
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [31:0]          cfg_data,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic                 s_mode,
    input  logic [31:0]          s_vector_word,
    input  logic [31:0]          s_item_norm,
    input  logic signed [31:0]   s_item_bias,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic signed [63:0]   m_score,
    output logic [15:0]          m_item_index,
    output logic                 m_last_item
);

    localparam int PTR_W = (MAX_WORDS > 1) ? $clog2(MAX_WORDS) : 1;
    localparam int CNT_W = $clog2(MAX_WORDS + 1);
    localparam int SUM_W = $clog2(32 * MAX_WORDS + 1);
    localparam int LW_W  = (CNT_W > 7) ? CNT_W : 7;
    localparam int Q_W   = SUM_W + CNT_W + JOB_W;

    logic [6:0]         latent_words_reg;
    logic [31:0]        usr_scale_reg;
    logic signed [31:0] usr_offset_reg;
    logic [16:0]        item_count_reg;

    logic [LW_W-1:0]  lw_ext;
    logic [CNT_W-1:0] words_eff;
    logic [16:0]      items_eff;

    logic             q_push;
    logic             q_full;
    logic             q_pop;
    logic             q_valid;
    job_t             f_job;
    logic [SUM_W-1:0] f_sum;
    logic [CNT_W-1:0] f_words;
    logic [Q_W-1:0]   q_out;
    job_t             b_job;
    logic [SUM_W-1:0] b_sum;
    logic [CNT_W-1:0] b_words;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            latent_words_reg <= 7'd1;
            usr_scale_reg    <= 32'd65536;
            usr_offset_reg   <= '0;
            item_count_reg   <= 17'd1;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                REG_LATENT_WORDS: latent_words_reg <= cfg_data[6:0];
                REG_USR_SCALE:    usr_scale_reg    <= cfg_data;
                REG_USR_OFFSET:   usr_offset_reg   <= $signed(cfg_data);
                REG_ITEM_COUNT:   item_count_reg   <= cfg_data[16:0];
                default: ;
            endcase
        end
    end

    // A word count of zero acts as one; counts beyond the store act as its depth.
    assign lw_ext = LW_W'(latent_words_reg);

    always_comb begin
        priority if (lw_ext == '0) begin
            words_eff = CNT_W'(1);
        end else if (lw_ext > LW_W'(MAX_WORDS)) begin
            words_eff = CNT_W'(MAX_WORDS);
        end else begin
            words_eff = CNT_W'(lw_ext);
        end
    end

    always_comb begin
        priority if (item_count_reg == '0) begin
            items_eff = 17'd1;
        end else if (item_count_reg > MAX_ITEMS) begin
            items_eff = MAX_ITEMS;
        end else begin
            items_eff = item_count_reg;
        end
    end

    xps_front #(
        .MAX_WORDS (MAX_WORDS),
        .PTR_W     (PTR_W),
        .CNT_W     (CNT_W),
        .SUM_W     (SUM_W)
    ) u_front (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_mode        (s_mode),
        .s_vector_word (s_vector_word),
        .s_item_norm   (s_item_norm),
        .s_item_bias   (s_item_bias),
        .words_eff     (words_eff),
        .items_eff     (items_eff),
        .q_full        (q_full),
        .q_push        (q_push),
        .q_job         (f_job),
        .q_sum         (f_sum),
        .q_words       (f_words)
    );

    xps_queue #(
        .WIDTH (Q_W)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_data ({f_sum, f_words, f_job}),
        .full      (q_full),
        .pop       (q_pop),
        .valid     (q_valid),
        .pop_data  (q_out)
    );

    assign b_sum   = q_out[Q_W-1 -: SUM_W];
    assign b_words = q_out[JOB_W +: CNT_W];
    assign b_job   = q_out[JOB_W-1:0];

    xps_back #(
        .CNT_W (CNT_W),
        .SUM_W (SUM_W)
    ) u_back (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .q_valid      (q_valid),
        .q_pop        (q_pop),
        .q_job        (b_job),
        .q_sum        (b_sum),
        .q_words      (b_words),
        .usr_scale    (usr_scale_reg),
        .usr_offset   (usr_offset_reg),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_score      (m_score),
        .m_item_index (m_item_index),
        .m_last_item  (m_last_item)
    );

endmodule
